// File: sv/slsa_pkg.sv
`default_nettype none
package slsa_pkg;

    // Width of the element count actually used; the input port is 16 bits wide.
    localparam int COUNT_BITS = 16;
    localparam int COUNT_W    = 16;
    localparam logic [COUNT_W-1:0] COUNT_MASK =
        (COUNT_BITS >= COUNT_W) ? {COUNT_W{1'b1}} : COUNT_W'((1 << COUNT_BITS) - 1);

    localparam int ESIZE_W = 7;                  // largest element size is 84
    localparam int MSIZE_W = ESIZE_W + COUNT_W;  // element size times count
    localparam int TOTAL_W = 32;
    localparam int ALIGN_W = 4;                  // alignment 1..8
    localparam int REM_W   = 3;                  // remainder 0..7

    localparam logic [ALIGN_W-1:0] ALIGN_MAX = 4'd8;
    localparam logic [ALIGN_W-1:0] ALIGN_MIN = 4'd1;

    localparam logic [3:0] TC_BOOL   = 4'd0;
    localparam logic [3:0] TC_SINT   = 4'd1;
    localparam logic [3:0] TC_INT    = 4'd2;
    localparam logic [3:0] TC_DINT   = 4'd3;
    localparam logic [3:0] TC_LINT   = 4'd4;
    localparam logic [3:0] TC_REAL   = 4'd5;
    localparam logic [3:0] TC_LREAL  = 4'd6;
    localparam logic [3:0] TC_USINT  = 4'd7;
    localparam logic [3:0] TC_UINT   = 4'd8;
    localparam logic [3:0] TC_UDINT  = 4'd9;
    localparam logic [3:0] TC_ULINT  = 4'd10;
    localparam logic [3:0] TC_STRING = 4'd11;

    function automatic logic [ESIZE_W-1:0] elem_size(input logic [3:0] code);
        logic [ESIZE_W-1:0] sz;
        case (code)
            TC_BOOL, TC_SINT, TC_USINT: sz = 7'd1;
            TC_INT, TC_UINT:            sz = 7'd2;
            TC_DINT, TC_REAL, TC_UDINT: sz = 7'd4;
            TC_LINT, TC_LREAL, TC_ULINT: sz = 7'd8;
            TC_STRING:                  sz = 7'd84;
            default:                    sz = 7'd0;
        endcase
        return sz;
    endfunction

endpackage
`default_nettype wire

// File: sv/struct_layout_size_accumulator.sv
`default_nettype none
// Places structure members one per input transfer and reports each member's
// padded offset and the running structure size. A new member is taken only
// when the previous result has been transferred, in the cycle after the result
// transfer at the earliest. The remainder unit reduces the 32-bit running total
// modulo the alignment one byte per cycle, and the single adder forms the
// offset and then the new total in two passes. first_member restarts the total
// and the overflow flag; overflow stays set until the next restart.
module struct_layout_size_accumulator
    import slsa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_first_member,
    input  wire logic               s_last_member,
    input  wire logic [3:0]         s_type_code,
    input  wire logic               s_is_array,
    input  wire logic [COUNT_W-1:0] s_element_count,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [TOTAL_W-1:0]      m_member_offset,
    output logic [TOTAL_W-1:0]      m_running_total,
    output logic                    m_size_done,
    output logic                    m_overflow
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_STRT = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_ADD1 = 3'd4;
    localparam logic [2:0] ST_ADD2 = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [TOTAL_W-1:0] total_reg;
    logic               wrap_reg;
    logic [TOTAL_W-1:0] offset_reg;
    logic               carry_reg;
    logic               last_reg;
    logic [ESIZE_W-1:0] esize_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [MSIZE_W-1:0] msize_reg;

    logic [ALIGN_W-1:0] align;
    logic [ALIGN_W-1:0] pad;
    logic               rem_done;
    logic [REM_W-1:0]   rem;
    logic [TOTAL_W-1:0] add_a, add_b;
    logic [TOTAL_W:0]   add_sum;

    wire s_xfer = s_valid && s_ready;
    wire m_xfer = m_valid && m_ready;

    always_comb begin
        if (msize_reg == '0) begin
            align = ALIGN_MIN;
        end else if (msize_reg > MSIZE_W'(ALIGN_MAX)) begin
            align = ALIGN_MAX;
        end else begin
            align = msize_reg[ALIGN_W-1:0];
        end
    end

    slsa_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_STRT),
        .dividend (total_reg),
        .divisor  (align),
        .done     (rem_done),
        .rem      (rem)
    );

    assign pad = (rem == '0) ? '0 : (align - ALIGN_W'(rem));

    // Shared adder: offset = total + pad, then new total = offset + member size.
    always_comb begin
        if (state_reg == ST_ADD1) begin
            add_a = total_reg;
            add_b = TOTAL_W'(pad);
        end else begin
            add_a = offset_reg;
            add_b = TOTAL_W'(msize_reg);
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_STRT;
            ST_STRT: state_next = ST_WAIT;
            ST_WAIT: if (rem_done) state_next = ST_ADD1;
            ST_ADD1: state_next = ST_ADD2;
            ST_ADD2: state_next = ST_OUT;
            ST_OUT:  if (m_xfer) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            wrap_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_xfer && s_first_member) begin
                total_reg <= '0;
                wrap_reg  <= 1'b0;
            end
            if (state_reg == ST_ADD2) begin
                total_reg <= add_sum[TOTAL_W-1:0];
                wrap_reg  <= wrap_reg | carry_reg | add_sum[TOTAL_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            last_reg  <= s_last_member;
            esize_reg <= elem_size(s_type_code);
            count_reg <= s_is_array ? (s_element_count & COUNT_MASK) : COUNT_W'(1);
        end
        if (state_reg == ST_MUL) begin
            msize_reg <= MSIZE_W'(esize_reg) * MSIZE_W'(count_reg);
        end
        if (state_reg == ST_ADD1) begin
            offset_reg <= add_sum[TOTAL_W-1:0];
            carry_reg  <= add_sum[TOTAL_W];
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_member_offset = offset_reg;
    assign m_running_total = total_reg;
    assign m_size_done     = last_reg;
    assign m_overflow      = wrap_reg;

endmodule
`default_nettype wire

// File: sv/slsa_rem_unit.sv
`default_nettype none
module slsa_rem_unit
    import slsa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [TOTAL_W-1:0] dividend,
    input  wire logic [ALIGN_W-1:0] divisor,
    output logic                    done,
    output logic [REM_W-1:0]        rem
);

    logic [TOTAL_W-1:0] div_reg;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [1:0]         cnt_reg;
    logic               run_reg;
    logic               done_reg;

    // One byte of the dividend per cycle, most significant first.
    always_comb begin
        logic [ALIGN_W-1:0] t;
        logic [REM_W-1:0]   r;
        r = rem_reg;
        for (int i = 7; i >= 0; i--) begin
            t = {r, div_reg[TOTAL_W-8+i]};
            if (t >= divisor) begin
                t = t - divisor;
            end
            r = t[REM_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= dividend;
            rem_reg <= '0;
        end else if (run_reg) begin
            div_reg <= {div_reg[TOTAL_W-9:0], 8'd0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire
